// ----- sv/pps_pkg.sv -----
// Package for the preemptive priority scheduler: widths, codes, command/status structs.
// No dependencies.
`default_nettype none
package pps_pkg;
   localparam int MaxJobsDefault = 16;
   localparam logic [23:0] Max24 = 24'hFFFFFF;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [1:0] RES_SEG    = 2'd0;
   localparam logic [1:0] RES_DONE   = 2'd1;
   localparam logic [1:0] RES_REJECT = 2'd2;

   typedef struct packed {
      logic clear;       // clear table and time
      logic load;        // write request into table at loaded_ff
      logic scan_start;  // reset selection, point at entry 0
      logic scan_step;   // evaluate entry, advance pointer
      logic wait_start;  // apply run unit, advance time
      logic wait_step;   // waiting update on entry, advance pointer
      logic emit_reject;
      logic emit_idle;   // emit idle segment and advance time
      logic emit_close;  // close open segment
      logic emit_done;   // completion record
      logic open_seg;    // start segment for selected job
      logic mark_done;
      logic last;
   } pps_cmd_type;

   typedef struct packed {
      logic scan_end;    // pointer on final loaded entry
      logic found;
      logic table_full;
      logic all_done;    // no unfinished jobs
      logic run_valid;
      logic run_match;   // running id equals selected id
      logic sel_one;     // selected job has one unit left before the run
      logic sel_finish;  // selected job has no units left after the run
   } pps_sts_type;
endpackage
`default_nettype wire

// ----- sv/pps_datapath.sv -----
// Datapath of the scheduler: job table, selection registers, time and output register.
// Depends on pps_pkg.
`default_nettype none
module pps_datapath #(
   parameter int MAX_JOBS = pps_pkg::MaxJobsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pps_pkg::pps_cmd_type cmd,
   output pps_pkg::pps_sts_type      sts,
   input  wire logic [7:0]           req_job_id,
   input  wire logic [15:0]          req_arrival,
   input  wire logic [15:0]          req_burst,
   input  wire logic [7:0]           req_prio,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_result_kind,
   output logic                      rsp_idle,
   output logic [7:0]                rsp_owner_id,
   output logic [23:0]               rsp_seg_start,
   output logic [23:0]               rsp_seg_end,
   output logic [23:0]               rsp_turnaround,
   output logic [23:0]               rsp_waited,
   output logic                      rsp_last
);
   import pps_pkg::*;
   localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CW = $clog2(MAX_JOBS + 1);

   logic [7:0]  id_mem_ff   [MAX_JOBS];
   logic [15:0] arr_mem_ff  [MAX_JOBS];
   logic [7:0]  prio_mem_ff [MAX_JOBS];
   logic [15:0] rem_mem_ff  [MAX_JOBS];
   logic [23:0] wait_mem_ff [MAX_JOBS];
   logic [MAX_JOBS-1:0] done_ff;

   logic [CW-1:0] loaded_ff, done_cnt_ff;
   logic [23:0]   now_ff;
   logic          run_valid_ff;
   logic [7:0]    run_id_ff;
   logic [23:0]   run_since_ff;

   logic [IW-1:0] ptr_ff;
   logic          found_ff;
   logic [IW-1:0] sel_ff;
   logic [7:0]    sel_prio_ff;
   logic [15:0]   sel_arr_ff;

   logic [CW-1:0] load_idx;
   logic [IW-1:0] load_ptr;
   logic [23:0]   now_inc;
   logic          cand, better;

   assign load_idx = loaded_ff;
   assign load_ptr = load_idx[IW-1:0];
   assign now_inc  = (now_ff == Max24) ? Max24 : now_ff + 24'd1;
   assign cand     = !done_ff[ptr_ff] && ({8'd0, arr_mem_ff[ptr_ff]} <= now_ff);
   assign better   = !found_ff || (prio_mem_ff[ptr_ff] < sel_prio_ff) ||
                     (prio_mem_ff[ptr_ff] == sel_prio_ff && arr_mem_ff[ptr_ff] < sel_arr_ff);

   always_comb begin
      sts.scan_end   = (CW'(ptr_ff) + CW'(1)) >= loaded_ff;
      sts.found      = found_ff;
      sts.table_full = loaded_ff >= CW'(MAX_JOBS);
      sts.all_done   = done_cnt_ff >= loaded_ff;
      sts.run_valid  = run_valid_ff;
      sts.run_match  = run_id_ff == id_mem_ff[sel_ff];
      sts.sel_one    = rem_mem_ff[sel_ff] == 16'd1;
      sts.sel_finish = rem_mem_ff[sel_ff] == 16'd0;
   end

   // table
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_mem_ff[load_ptr]   <= req_job_id;
         arr_mem_ff[load_ptr]  <= req_arrival;
         prio_mem_ff[load_ptr] <= req_prio;
         rem_mem_ff[load_ptr]  <= req_burst;
         wait_mem_ff[load_ptr] <= 24'd0;
      end
      if (cmd.wait_start && rem_mem_ff[sel_ff] != 16'd0)
         rem_mem_ff[sel_ff] <= rem_mem_ff[sel_ff] - 16'd1;
      // time already advanced when wait_step runs
      if (cmd.wait_step && ptr_ff != sel_ff && !done_ff[ptr_ff] &&
          {8'd0, arr_mem_ff[ptr_ff]} < now_ff && rem_mem_ff[ptr_ff] != 16'd0 &&
          wait_mem_ff[ptr_ff] != Max24)
         wait_mem_ff[ptr_ff] <= wait_mem_ff[ptr_ff] + 24'd1;
   end

   // control and selection
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         done_ff      <= '0;
         loaded_ff    <= '0;
         done_cnt_ff  <= '0;
         now_ff       <= '0;
         run_valid_ff <= 1'b0;
         run_id_ff    <= '0;
         run_since_ff <= '0;
         ptr_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         if (cmd.load) begin
            done_ff[load_ptr] <= 1'b0;
            loaded_ff <= loaded_ff + CW'(1);
         end
         if (cmd.scan_start) begin
            ptr_ff   <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (cand && better) begin
               found_ff <= 1'b1;
               sel_ff <= ptr_ff;
               sel_prio_ff <= prio_mem_ff[ptr_ff];
               sel_arr_ff <= arr_mem_ff[ptr_ff];
            end
            ptr_ff <= ptr_ff + IW'(1);
         end
         if (cmd.wait_start) begin
            now_ff <= now_inc;
            ptr_ff <= '0;
         end
         if (cmd.wait_step) ptr_ff <= ptr_ff + IW'(1);
         if (cmd.emit_idle) now_ff <= now_inc;
         if (cmd.emit_close) run_valid_ff <= 1'b0;
         if (cmd.open_seg) begin
            run_valid_ff <= 1'b1;
            run_id_ff    <= id_mem_ff[sel_ff];
            run_since_ff <= now_ff;
         end
         if (cmd.mark_done) begin
            done_ff[sel_ff] <= 1'b1;
            done_cnt_ff <= done_cnt_ff + CW'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= cmd.emit_reject | cmd.emit_idle | cmd.emit_close | cmd.emit_done;
      rsp_last       <= cmd.last;
      rsp_idle       <= 1'b0;
      rsp_seg_start  <= '0;
      rsp_seg_end    <= '0;
      rsp_turnaround <= '0;
      rsp_waited     <= '0;
      rsp_owner_id   <= '0;
      rsp_result_kind <= RES_SEG;
      if (cmd.emit_reject) begin
         rsp_result_kind <= RES_REJECT;
         rsp_owner_id    <= req_job_id;
      end else if (cmd.emit_close) begin
         rsp_owner_id  <= run_id_ff;
         rsp_seg_start <= run_since_ff;
         rsp_seg_end   <= now_ff;
      end else if (cmd.emit_idle) begin
         rsp_idle      <= 1'b1;
         rsp_seg_start <= now_ff;
         rsp_seg_end   <= now_inc;
      end else if (cmd.emit_done) begin
         rsp_result_kind <= RES_DONE;
         rsp_owner_id    <= id_mem_ff[sel_ff];
         rsp_seg_end     <= now_ff;
         rsp_turnaround  <= now_ff - {8'd0, arr_mem_ff[sel_ff]};
         rsp_waited      <= wait_mem_ff[sel_ff];
      end
   end
endmodule
`default_nettype wire

// ----- sv/pps_control.sv -----
// Controller state machine of the scheduler: sequences load, scan, wait update and results.
// Depends on pps_pkg.
`default_nettype none
module pps_control (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_start,
   input  wire logic [1:0]           req_kind,
   input  wire logic [15:0]          req_burst,
   output logic                      busy,
   output pps_pkg::pps_cmd_type      cmd,
   input  wire pps_pkg::pps_sts_type sts
);
   import pps_pkg::*;
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_IDLSEG = 4'd3;
   localparam logic [3:0] S_SWITCH = 4'd4;
   localparam logic [3:0] S_RUN    = 4'd5;
   localparam logic [3:0] S_WAIT   = 4'd6;
   localparam logic [3:0] S_CLOSE  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign busy   = state_ff != S_IDLE;
   assign accept = req_start && !busy;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            case (req_kind)
               KIND_CLEAR: cmd.clear = 1'b1;
               KIND_LOAD: begin
                  if (req_burst == 16'd0 || sts.table_full) begin
                     cmd.emit_reject = 1'b1;
                     cmd.last = 1'b1;
                  end else cmd.load = 1'b1;
               end
               KIND_TICK: if (!sts.all_done) begin
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_end) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!sts.found) begin
               if (sts.run_valid) cmd.emit_close = 1'b1;
               state_in = S_IDLSEG;
            end else if (!sts.run_valid || !sts.run_match) begin
               // closing the preempted segment ends the request unless the new job finishes
               if (sts.run_valid) begin
                  cmd.emit_close = 1'b1;
                  cmd.last = !sts.sel_one;
               end
               state_in = S_SWITCH;
            end else state_in = S_RUN;
         end
         S_IDLSEG: begin
            cmd.emit_idle = 1'b1;
            cmd.last = 1'b1;
            state_in = S_IDLE;
         end
         S_SWITCH: begin
            cmd.open_seg = 1'b1;
            state_in = S_RUN;
         end
         S_RUN: begin
            cmd.wait_start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.wait_step = 1'b1;
            if (sts.scan_end) state_in = sts.sel_finish ? S_CLOSE : S_IDLE;
         end
         S_CLOSE: begin
            // sel_finish now sees the decremented count (zero)
            cmd.emit_close = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.emit_done = 1'b1;
            cmd.mark_done = 1'b1;
            cmd.last = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ----- sv/preemptive_priority_scheduler.sv -----
// Top level of the preemptive priority scheduler: controller plus datapath.
// Depends on pps_pkg, pps_control, pps_datapath.
//
// Requests are accepted when start is high and busy is low. Clear and load
// finish without raising busy; a rejected load gives its result the next
// cycle. A tick walks the job table one entry a cycle to pick the job and,
// when one is picked, walks it again to count waiting. Results appear on
// the rsp_ ports for exactly one cycle, flagged by rsp_valid; the receiver
// cannot stall them, so it must take every strobed result. rsp_last marks
// the final result of a request. Ticks after all jobs have finished give
// nothing and leave time unchanged.
`default_nettype none
module preemptive_priority_scheduler #(
   parameter int MAX_JOBS = pps_pkg::MaxJobsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_job_id,
   input  wire logic [15:0] req_arrival,
   input  wire logic [15:0] req_burst,
   input  wire logic [7:0]  req_prio,
   output logic             rsp_valid,
   output logic [1:0]       rsp_result_kind,
   output logic             rsp_idle,
   output logic [7:0]       rsp_owner_id,
   output logic [23:0]      rsp_seg_start,
   output logic [23:0]      rsp_seg_end,
   output logic [23:0]      rsp_turnaround,
   output logic [23:0]      rsp_waited,
   output logic             rsp_last
);
   import pps_pkg::*;
   pps_cmd_type cmd;
   pps_sts_type sts;

   pps_control u_ctrl (
      .clock, .reset, .req_start(start), .req_kind, .req_burst, .busy, .cmd, .sts
   );

   pps_datapath #(.MAX_JOBS(MAX_JOBS)) u_dp (
      .clock, .reset, .cmd, .sts, .req_job_id, .req_arrival, .req_burst, .req_prio,
      .rsp_valid, .rsp_result_kind, .rsp_idle, .rsp_owner_id, .rsp_seg_start,
      .rsp_seg_end, .rsp_turnaround, .rsp_waited, .rsp_last
   );
endmodule
`default_nettype wire

// ----- sim/preemptive_priority_scheduler_test.sv -----
// Self-checking testbench for preemptive_priority_scheduler: directed and random requests,
// with results predicted by a behavioural job table. Depends on pps_pkg and the scheduler RTL.
`default_nettype none
module preemptive_priority_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pps_pkg::*;

   localparam int NumJobs = MaxJobsDefault;
   localparam int CycleLimit = 400000;
   localparam logic [1:0] KindUnused = 2'd3;

   // one expected result record
   typedef struct {
      logic [1:0]  kind;
      logic        idle;
      logic [7:0]  owner;
      logic [23:0] seg_start;
      logic [23:0] seg_end;
      logic [23:0] turnaround;
      logic [23:0] waited;
      logic        last;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = '0;
   logic [7:0]  req_job_id = '0;
   logic [15:0] req_arrival = '0;
   logic [15:0] req_burst = '0;
   logic [7:0]  req_prio = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_result_kind;
   logic        rsp_idle;
   logic [7:0]  rsp_owner_id;
   logic [23:0] rsp_seg_start;
   logic [23:0] rsp_seg_end;
   logic [23:0] rsp_turnaround;
   logic [23:0] rsp_waited;
   logic        rsp_last;

   preemptive_priority_scheduler i_dut (
      .clock, .reset, .start, .busy,
      .req_kind, .req_job_id, .req_arrival, .req_burst, .req_prio,
      .rsp_valid, .rsp_result_kind, .rsp_idle, .rsp_owner_id, .rsp_seg_start,
      .rsp_seg_end, .rsp_turnaround, .rsp_waited, .rsp_last
   );

   always #1 clock = ~clock;

   // ---- shadow job table ----
   logic [7:0]    job_id_tab [NumJobs];
   logic [15:0]   job_arr_tab [NumJobs];
   logic [7:0]    job_prio_tab [NumJobs];
   logic [15:0]   job_left_tab [NumJobs];
   logic [23:0]   job_wait_tab [NumJobs];
   logic          job_done_tab [NumJobs];
   int            jobs_loaded;
   int            jobs_done;
   logic [23:0]   sched_now;
   logic          seg_open;
   logic [7:0]    seg_owner;
   logic [23:0]   seg_since;

   sched_result_type pending_results[$];
   int            fail_count = 0;
   int            cycle_count = 0;
   bit            quiet = 1'b0;     // no sender gaps in the closing part
   bit            id_used [256];    // keeps ids unique within one table fill

   function automatic logic [23:0] sat_up(logic [23:0] v);
      return (v == Max24) ? Max24 : v + 24'd1;
   endfunction

   function automatic void add_result(logic [1:0] k, logic idl, logic [7:0] own,
                                      logic [23:0] s, logic [23:0] e,
                                      logic [23:0] tat, logic [23:0] w);
      sched_result_type r;
      r = '{k, idl, own, s, e, tat, w, 1'b0};
      pending_results.push_back(r);
   endfunction

   function automatic void close_segment();
      if (seg_open)
         add_result(RES_SEG, 1'b0, seg_owner, seg_since, sched_now, '0, '0);
      seg_open = 1'b0;
   endfunction

   function automatic void clear_schedule();
      jobs_loaded = 0;
      jobs_done = 0;
      sched_now = '0;
      seg_open = 1'b0;
      seg_owner = '0;
      seg_since = '0;
      for (int i = 0; i < NumJobs; i++) job_done_tab[i] = 1'b0;
      for (int i = 0; i < 256; i++) id_used[i] = 1'b0;
   endfunction

   // one time unit of the scheduler
   function automatic void tick_schedule();
      int  sel;
      bit  found;
      sel = 0;
      found = 1'b0;
      if (jobs_done >= jobs_loaded) return;
      for (int i = 0; i < jobs_loaded; i++) begin
         if (job_done_tab[i] || 24'(job_arr_tab[i]) > sched_now) continue;
         if (!found || job_prio_tab[i] < job_prio_tab[sel] ||
             (job_prio_tab[i] == job_prio_tab[sel] && job_arr_tab[i] < job_arr_tab[sel])) begin
            sel = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         close_segment();
         add_result(RES_SEG, 1'b1, '0, sched_now, sat_up(sched_now), '0, '0);
         sched_now = sat_up(sched_now);
         return;
      end
      // preemption or first dispatch closes the old segment
      if (!seg_open || seg_owner != job_id_tab[sel]) begin
         close_segment();
         seg_open = 1'b1;
         seg_owner = job_id_tab[sel];
         seg_since = sched_now;
      end
      if (job_left_tab[sel] != 0) job_left_tab[sel]--;
      sched_now = sat_up(sched_now);
      for (int i = 0; i < jobs_loaded; i++)
         if (i != sel && !job_done_tab[i] && 24'(job_arr_tab[i]) < sched_now &&
             job_left_tab[i] != 0)
            job_wait_tab[i] = sat_up(job_wait_tab[i]);
      if (job_left_tab[sel] == 0) begin
         close_segment();
         job_done_tab[sel] = 1'b1;
         jobs_done++;
         add_result(RES_DONE, 1'b0, job_id_tab[sel], '0, sched_now,
                    sched_now - 24'(job_arr_tab[sel]), job_wait_tab[sel]);
      end
   endfunction

   function automatic void predict_request(logic [1:0] k, logic [7:0] id, logic [15:0] arr,
                                           logic [15:0] bur, logic [7:0] pri);
      int before_n;
      before_n = pending_results.size();
      if (k == KIND_CLEAR) begin
         clear_schedule();
      end else if (k == KIND_LOAD) begin
         if (bur == 0 || jobs_loaded >= NumJobs) begin
            add_result(RES_REJECT, 1'b0, id, '0, '0, '0, '0);
         end else begin
            job_id_tab[jobs_loaded] = id;
            job_arr_tab[jobs_loaded] = arr;
            job_prio_tab[jobs_loaded] = pri;
            job_left_tab[jobs_loaded] = bur;
            job_wait_tab[jobs_loaded] = '0;
            job_done_tab[jobs_loaded] = 1'b0;
            jobs_loaded++;
         end
      end else if (k == KIND_TICK) begin
         tick_schedule();
      end
      if (pending_results.size() > before_n)
         pending_results[pending_results.size() - 1].last = 1'b1;
   endfunction

   // ---- driver ----
   task automatic send_request(logic [1:0] k, logic [7:0] id, logic [15:0] arr,
                               logic [15:0] bur, logic [7:0] pri);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_kind = k;
      req_job_id = id;
      req_arrival = arr;
      req_burst = bur;
      req_prio = pri;
      do @(posedge clock); while (busy);
      predict_request(k, id, arr, bur, pri);
   endtask

   task automatic load_job(logic [7:0] id, logic [15:0] arr, logic [15:0] bur,
                           logic [7:0] pri);
      send_request(KIND_LOAD, id, arr, bur, pri);
   endtask

   task automatic tick_n(int n);
      for (int i = 0; i < n; i++)
         send_request(KIND_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic clear_table();
      send_request(KIND_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (2 * NumJobs + 10) @(negedge clock);
   endtask

   // ---- tests ----
   task automatic test_directed();
      tick_n(1);                                   // empty table: nothing
      load_job(8'hFF, 16'd0, 16'd0, 8'd3);         // zero burst reject
      load_job(8'h10, 16'd2, 16'd3, 8'd5);
      load_job(8'h20, 16'd0, 16'd2, 8'd9);
      load_job(8'h30, 16'd3, 16'd1, 8'd0);         // preempts on arrival
      load_job(8'h40, 16'd0, 16'd1, 8'hFF);
      send_request(KindUnused, 8'h55, 16'hFFFF, 16'hFFFF, 8'hFF);  // unused kind
      tick_n(10);                                  // runs past completion
      clear_table();
      load_job(8'h01, 16'd3, 16'd2, 8'd1);         // idle before arrival
      load_job(8'h02, 16'd3, 16'd1, 8'd1);         // full tie: lower index wins
      tick_n(7);
   endtask

   task automatic test_full_table();
      clear_table();
      for (int i = 0; i < NumJobs + 2; i++)
         load_job(8'(i), 16'(i % 3), 16'd1, 8'(i % 4));
      tick_n(NumJobs + 1);
   endtask

   // random episodes: fill a table, run it, sometimes starve or overflow it
   task automatic test_random(int budget);
      int  sent;
      int  n;
      int  id;
      logic [15:0] arr;
      logic [15:0] bur;
      sent = 0;
      while (sent < budget) begin
         clear_table();
         sent++;
         n = $urandom_range(1, NumJobs + 2);
         for (int j = 0; j < n; j++) begin
            do id = $urandom_range(0, 255); while (id_used[id]);
            id_used[id] = 1'b1;
            arr = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
            case ($urandom_range(0, 9))
               0: bur = 16'd0;
               1: bur = 16'($urandom);
               default: bur = 16'($urandom_range(1, 5));
            endcase
            load_job(8'(id), arr, bur,
                     ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
            sent++;
            if ($urandom_range(0, 5) == 0) begin
               tick_n(1);
               sent++;
            end
         end
         n = $urandom_range(5, 30);
         tick_n(n);
         sent += n;
      end
   endtask

   task automatic test_drain_pause();
      clear_table();
      load_job(8'hA5, 16'd1, 16'd2, 8'd7);
      tick_n(2);
      wait_drained();                              // sender holds until all results are in
      load_job(8'h5A, 16'd0, 16'd1, 8'd0);
      tick_n(3);
   endtask

   // ---- result checker ----
   always @(posedge clock) begin
      sched_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d owner %0h", rsp_result_kind, rsp_owner_id);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_result_kind !== e.kind) begin
               $error("result_kind exp %0d got %0d", e.kind, rsp_result_kind); fail_count++;
            end
            if (rsp_idle !== e.idle) begin
               $error("idle exp %0d got %0d", e.idle, rsp_idle); fail_count++;
            end
            if (rsp_owner_id !== e.owner) begin
               $error("owner_id exp %0h got %0h", e.owner, rsp_owner_id); fail_count++;
            end
            if (rsp_seg_start !== e.seg_start) begin
               $error("seg_start exp %0d got %0d", e.seg_start, rsp_seg_start); fail_count++;
            end
            if (rsp_seg_end !== e.seg_end) begin
               $error("seg_end exp %0d got %0d", e.seg_end, rsp_seg_end); fail_count++;
            end
            if (rsp_turnaround !== e.turnaround) begin
               $error("turnaround exp %0d got %0d", e.turnaround, rsp_turnaround);
               fail_count++;
            end
            if (rsp_waited !== e.waited) begin
               $error("waited exp %0d got %0d", e.waited, rsp_waited); fail_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last); fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      clear_schedule();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_full_table();
      test_random(200);
      test_drain_pause();
      quiet = 1'b1;
      test_random(50);
      wait_drained();
      if (pending_results.size() == 0 && fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
sv/pps_pkg.sv
sv/pps_datapath.sv
sv/pps_control.sv
sv/preemptive_priority_scheduler.sv
sim/preemptive_priority_scheduler_test.sv
